// File: sv/odle_pkg.sv
`default_nettype none
package odle_pkg;

    localparam int LOOP_DEPTH  = 524288;
    localparam int TAP_SPACING = 512;
    localparam int TAP_COUNT   = 4;

    localparam int ADDR_W     = $clog2(LOOP_DEPTH);
    localparam int SAMPLE_W   = 24;
    localparam int TAP_DIV    = TAP_COUNT + 1;
    localparam int TAP_CNT_W  = $clog2(TAP_COUNT + 1);
    localparam int ACC_W      = SAMPLE_W + $clog2(TAP_COUNT + 1) + 1;

    localparam int MAG_W      = SAMPLE_W;
    localparam int DIV_SHIFT  = MAG_W + $clog2(TAP_DIV);
    localparam int RECIP_W    = DIV_SHIFT + 1 - $clog2(TAP_DIV);
    localparam longint RECIP  = ((longint'(1) << DIV_SHIFT) + TAP_DIV - 1) / TAP_DIV;
    localparam int PROD_W     = MAG_W + RECIP_W;

    localparam logic [ADDR_W-1:0] QUARTER_STEP = ADDR_W'(LOOP_DEPTH / 4);
    localparam logic [ADDR_W-1:0] TAP_STEP     = ADDR_W'(TAP_SPACING % LOOP_DEPTH);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SKIP   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic accept;
        logic skip;
        logic rd_tap;
        logic rd_pos;
        logic clr_wr;
        logic wr_result;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic clr_last;
        logic out_busy;
    } t_dp_sts;

endpackage
`default_nettype wire

// File: sv/odle_ctrl.sv
`default_nettype none
module odle_ctrl
    import odle_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic [1:0]   i_opcode,
    input  wire t_dp_sts      i_sts,
    output logic              o_in_stall,
    output t_dp_cmd           o_cmd
);

    t_state                 r_state, n_state;
    logic [TAP_CNT_W-1:0]   r_tap_cnt, n_tap_cnt;
    logic                   w_accept;
    logic                   w_taps_done;

    assign w_accept    = (r_state == ST_IDLE) && i_in_valid;
    assign w_taps_done = (r_tap_cnt == TAP_CNT_W'(TAP_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_tap_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_tap_cnt <= n_tap_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_SAMPLE) n_state = ST_READ;
                    else if (i_opcode == OP_CLEAR) n_state = ST_CLEAR;
                end
            end
            ST_READ: begin
                if (w_taps_done) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (!i_sts.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_tap_cnt = r_tap_cnt;
        if (w_accept) n_tap_cnt = '0;
        else if (r_state == ST_READ && !w_taps_done) n_tap_cnt = r_tap_cnt + 1'b1;
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                o_cmd.skip   = i_in_valid && (i_opcode == OP_SKIP);
            end
            ST_READ: begin
                o_cmd.rd_tap = !w_taps_done;
                o_cmd.rd_pos = w_taps_done;
            end
            ST_DRAIN: begin
            end
            ST_WRITE: begin
                o_cmd.wr_result = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/odle_datapath.sv
`default_nettype none
module odle_datapath
    import odle_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    input  wire logic signed [SAMPLE_W-1:0] i_tone_sample,
    input  wire logic                       i_echo_on,
    input  wire logic                       i_out_stall,
    output t_dp_sts                         o_sts,
    output logic                            o_out_valid,
    output logic signed [SAMPLE_W-1:0]      o_out_sample,
    output logic                            o_clipped
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((longint'(1) << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(longint'(1) << (SAMPLE_W - 1));
    localparam logic [RECIP_W-1:0]      RECIP_C = RECIP_W'(RECIP);

    logic [SAMPLE_W-1:0]        r_mem [LOOP_DEPTH];

    logic [ADDR_W-1:0]          r_pos;
    logic [ADDR_W-1:0]          r_tap_off;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic                       r_echo;
    logic                       r_p1_vld, r_p1_tap;
    logic                       r_p2_vld, r_p2_neg;
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic [PROD_W-1:0]          r_prod;
    logic signed [SAMPLE_W-1:0] r_old;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_clipped;

    logic [ADDR_W-1:0]          w_addr;
    logic                       w_we;
    logic [SAMPLE_W-1:0]        w_wdata;
    logic [MAG_W-1:0]           w_mag;
    logic [MAG_W-1:0]           w_quot;
    logic signed [ACC_W-1:0]    w_quot_ext;
    logic signed [ACC_W-1:0]    w_sum;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic                       w_clip;

    always_comb begin
        w_addr = r_pos;
        if (i_cmd.clr_wr) w_addr = r_clr_addr;
        else if (i_cmd.rd_tap) w_addr = r_pos - r_tap_off;
    end

    assign w_we    = i_cmd.clr_wr || i_cmd.wr_result;
    assign w_wdata = i_cmd.clr_wr ? '0 : w_sat;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rd_data <= r_mem[w_addr];
    end

    assign w_mag      = r_rd_data[SAMPLE_W-1] ? (~r_rd_data + 1'b1) : r_rd_data;
    assign w_quot     = MAG_W'(r_prod[PROD_W-1:DIV_SHIFT]);
    assign w_quot_ext = ACC_W'(w_quot);

    always_comb begin
        w_sum  = ACC_W'(r_old) + r_acc;
        w_clip = 1'b0;
        w_sat  = SAMPLE_W'(w_sum);
        if (w_sum > SAT_MAX) begin
            w_sat  = SAMPLE_W'(SAT_MAX);
            w_clip = 1'b1;
        end else if (w_sum < SAT_MIN) begin
            w_sat  = SAMPLE_W'(SAT_MIN);
            w_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_clr_addr  <= '0;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.rd_tap || i_cmd.rd_pos;
            r_p2_vld <= r_p1_vld && r_p1_tap && r_echo;
            if (i_cmd.skip) r_pos <= r_pos + QUARTER_STEP;
            else if (i_cmd.wr_result) r_pos <= r_pos + 1'b1;
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.wr_result) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_tap <= i_cmd.rd_tap;
        if (i_cmd.accept) begin
            r_echo    <= i_echo_on;
            r_tap_off <= TAP_STEP;
            r_acc     <= ACC_W'(i_tone_sample);
        end else begin
            if (i_cmd.rd_tap) r_tap_off <= r_tap_off + TAP_STEP;
            if (r_p2_vld) r_acc <= r_p2_neg ? (r_acc - w_quot_ext) : (r_acc + w_quot_ext);
        end
        if (r_p1_vld && r_p1_tap) begin
            r_prod   <= PROD_W'(w_mag) * PROD_W'(RECIP_C);
            r_p2_neg <= r_rd_data[SAMPLE_W-1];
        end
        if (r_p1_vld && !r_p1_tap) r_old <= r_rd_data;
        if (i_cmd.wr_result) begin
            r_out_sample <= w_sat;
            r_clipped    <= w_clip;
        end
    end

    assign o_sts.pipe_busy = r_p1_vld || r_p2_vld;
    assign o_sts.clr_last  = (r_clr_addr == ADDR_W'(LOOP_DEPTH - 1));
    assign o_sts.out_busy  = r_out_valid && i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_clipped    = r_clipped;

endmodule
`default_nettype wire

// File: sv/overdub_looper_echo_top.sv
// Overdub looper with multi-tap echo.
// Input channel: i_in_valid / o_in_stall carry one word of i_opcode,
// i_tone_sample and i_echo_on; a word is taken when valid is high and
// stall is low. Output channel: o_out_valid / i_out_stall carry
// o_out_sample and o_clipped, one word per sample opcode only.
// A sample word passes through an accept state, TAP_COUNT + 1 reads on the
// single loop memory port (5), a drain for the divide-by-reciprocal multiply
// and accumulate, and a write; the result appears on the cycle after the
// write. Skip and unused opcodes are accepted without leaving the idle state.
// A clear opcode sweeps the memory one entry per cycle, clearing all LOOP_DEPTH
// (524288) entries. After reset the same clearing sweep runs with o_in_stall
// high; the write position returns to zero.
// The output register holds a finished word while i_out_stall is high; the
// next sample word is accepted and processed meanwhile, and waits in its
// write cycle until the register frees up.
`default_nettype none
module overdub_looper_echo_top
    import odle_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic signed [SAMPLE_W-1:0] i_tone_sample,
    input  wire logic                       i_echo_on,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0]      o_out_sample,
    output logic                            o_clipped
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    odle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    odle_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_tone_sample (i_tone_sample),
        .i_echo_on     (i_echo_on),
        .i_out_stall   (i_out_stall),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .o_out_sample  (o_out_sample),
        .o_clipped     (o_clipped)
    );

endmodule
`default_nettype wire
